/* rtl/twadc_pkg.sv */
// Shared types and constants for the two-wire converter serial master.
// No dependencies; every other file in rtl/ imports this package.
package twadc_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int SAMPLE_MAX      = 24;

    // request codes on the input channel
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_CHAN0_SETUP = 2'd0;
    localparam logic [1:0] REG_CHAN1_SETUP = 2'd1;
    localparam logic [1:0] REG_HALF_PERIOD = 2'd2;
    localparam logic [1:0] REG_TIMEOUT     = 2'd3;

    localparam logic [7:0]  CHAN0_SETUP_RST = 8'd12;
    localparam logic [7:0]  CHAN1_SETUP_RST = 8'd13;
    localparam logic [15:0] HALF_PERIOD_RST = 16'd125;
    localparam logic [31:0] TIMEOUT_RST     = 32'd50000000;

    localparam logic [6:0] CMD_READ  = 7'h56;
    localparam logic [6:0] CMD_WRITE = 7'h65;

    typedef struct packed {
        logic [7:0]  chan0_setup;
        logic [7:0]  chan1_setup;
        logic [15:0] half_period_ticks;
        logic [31:0] ready_timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic                  sck_level;
        logic                  dout_drive;
        logic                  dout_enable;
        logic                  busy_res;
        logic                  done_res;
        logic                  status;
        logic [SAMPLE_MAX-1:0] sample;
        logic [7:0]            setup_readback;
    } res_t;

endpackage

/* rtl/twadc_cfg.sv */
// Configuration register file: setup bytes, half period and ready timeout.
// Depends on twadc_pkg.
module twadc_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output twadc_pkg::cfg_t    cfg
);
    import twadc_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.chan0_setup         <= CHAN0_SETUP_RST;
            cfg_reg.chan1_setup         <= CHAN1_SETUP_RST;
            cfg_reg.half_period_ticks   <= HALF_PERIOD_RST;
            cfg_reg.ready_timeout_ticks <= TIMEOUT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_CHAN0_SETUP: cfg_reg.chan0_setup         <= cfg_data[7:0];
                REG_CHAN1_SETUP: cfg_reg.chan1_setup         <= cfg_data[7:0];
                REG_HALF_PERIOD: cfg_reg.half_period_ticks   <= cfg_data[15:0];
                REG_TIMEOUT:     cfg_reg.ready_timeout_ticks <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

/* rtl/twadc_seq.sv */
// Pin-level sequencer: ready wait, clock pulse timing, shifting of sample,
// command and setup bits. One tick per advance. Depends on twadc_pkg.
module twadc_seq #(
    parameter int SAMPLE_BITS = twadc_pkg::SAMPLE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic [1:0]         opcode,
    input  logic               channel,
    input  logic               dout_in,
    input  twadc_pkg::cfg_t    cfg,
    output twadc_pkg::res_t    res
);
    import twadc_pkg::*;

    localparam int TOTAL = SAMPLE_BITS + 22;
    localparam int PW    = $clog2(TOTAL + 1);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_WAIT = 2'd1;
    localparam logic [1:0] PH_HIGH = 2'd2;
    localparam logic [1:0] PH_LOW  = 2'd3;

    // pulse offsets after the sample bits
    localparam logic [PW-1:0] Q_CMD_FIRST   = PW'(5);
    localparam logic [PW-1:0] Q_CMD_LAST    = PW'(11);
    localparam logic [PW-1:0] Q_TURN        = PW'(12);
    localparam logic [PW-1:0] Q_SETUP_FIRST = PW'(13);
    localparam logic [PW-1:0] Q_SETUP_LAST  = PW'(20);

    logic [1:0]             phase_reg, phase_next;
    logic [PW-1:0]          pulse_reg, pulse_next;
    logic [15:0]            half_reg, half_next;
    logic [31:0]            wait_reg, wait_next;
    logic [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic [7:0]             setup_reg, setup_next;
    logic [7:0]             devset_reg, devset_next;
    logic                   pend_reg, pend_next;
    logic                   tgt_reg, tgt_next;
    logic                   iswr_reg, iswr_next;

    logic [15:0]            hp;
    logic [31:0]            wait_inc;
    logic                   start_wait;
    logic                   done, tout, rdone;
    logic [PW-1:0]          q, qn;
    logic [6:0]             cmd;

    always_comb
    begin
        phase_next  = phase_reg;
        pulse_next  = pulse_reg;
        half_next   = half_reg;
        wait_next   = wait_reg;
        sample_next = sample_reg;
        setup_next  = setup_reg;
        devset_next = devset_reg;
        pend_next   = pend_reg;
        tgt_next    = tgt_reg;
        iswr_next   = iswr_reg;
        start_wait  = 1'b0;
        done        = 1'b0;
        tout        = 1'b0;
        rdone       = 1'b0;
        hp          = (cfg.half_period_ticks == '0) ? 16'd1 : cfg.half_period_ticks;
        wait_inc    = (wait_reg != '1) ? wait_reg + 32'd1 : wait_reg;
        q           = pulse_reg - PW'(SAMPLE_BITS);

        case (phase_reg)
            PH_IDLE:
            begin
                case (opcode)
                    OP_READ:
                    begin
                        tgt_next   = channel;
                        pend_next  = devset_reg[0] != channel;
                        iswr_next  = devset_reg[0] != channel;
                        start_wait = 1'b1;
                    end
                    OP_WRITE:
                    begin
                        tgt_next   = channel;
                        pend_next  = 1'b0;
                        iswr_next  = 1'b1;
                        start_wait = 1'b1;
                    end
                    default: ;
                endcase
            end
            PH_WAIT:
            begin
                if (!dout_in)
                begin
                    phase_next  = PH_HIGH;
                    half_next   = 16'd1;
                    pulse_next  = '0;
                    sample_next = '0;
                end
                else
                begin
                    wait_next = wait_inc;
                    if (wait_inc >= cfg.ready_timeout_ticks)
                    begin
                        // timeout of the setup write ahead of a read: run the read anyway
                        if (iswr_reg && pend_reg)
                        begin
                            iswr_next  = 1'b0;
                            pend_next  = 1'b0;
                            start_wait = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                            tout       = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                if (half_reg < hp)
                begin
                    half_next = half_reg + 16'd1;
                end
                else if (phase_reg == PH_HIGH)
                begin
                    phase_next = PH_LOW;
                    half_next  = 16'd1;
                end
                else
                begin
                    // end of low half: capture, then advance to the next pulse or end the transfer
                    if (pulse_reg < PW'(SAMPLE_BITS))
                    begin
                        sample_next = {sample_reg[SAMPLE_BITS-2:0], dout_in};
                    end
                    else if (!iswr_reg && q >= Q_SETUP_FIRST && q <= Q_SETUP_LAST)
                    begin
                        setup_next = {setup_reg[6:0], dout_in};
                    end
                    pulse_next = pulse_reg + PW'(1);
                    if (pulse_next >= PW'(TOTAL))
                    begin
                        if (iswr_reg && pend_reg)
                        begin
                            iswr_next  = 1'b0;
                            pend_next  = 1'b0;
                            start_wait = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                            rdone      = !iswr_reg;
                            if (!iswr_reg)
                            begin
                                devset_next = setup_next;
                            end
                        end
                    end
                    else
                    begin
                        phase_next = PH_HIGH;
                        half_next  = 16'd1;
                    end
                end
            end
        endcase

        if (start_wait)
        begin
            phase_next = PH_WAIT;
            wait_next  = '0;
            setup_next = iswr_next ? (tgt_next ? cfg.chan1_setup : cfg.chan0_setup) : 8'd0;
        end
    end

    // pin levels after this tick
    always_comb
    begin
        res             = '0;
        qn              = pulse_next - PW'(SAMPLE_BITS);
        cmd             = iswr_next ? CMD_WRITE : CMD_READ;
        res.busy_res    = phase_next != PH_IDLE;
        res.done_res    = done;
        res.status      = tout;
        if (rdone)
        begin
            res.sample = SAMPLE_MAX'(sample_next ^ {1'b1, {(SAMPLE_BITS-1){1'b0}}});
            res.setup_readback = setup_next;
        end
        if (phase_next == PH_HIGH || phase_next == PH_LOW)
        begin
            res.sck_level = phase_next == PH_HIGH;
            if (pulse_next >= PW'(SAMPLE_BITS))
            begin
                if (qn >= Q_CMD_FIRST && qn <= Q_CMD_LAST)
                begin
                    res.dout_enable = 1'b1;
                    res.dout_drive  = cmd[3'(Q_CMD_LAST - qn)];
                end
                else if (iswr_next && qn == Q_TURN)
                begin
                    res.dout_enable = 1'b1;
                end
                else if (iswr_next && qn >= Q_SETUP_FIRST && qn <= Q_SETUP_LAST)
                begin
                    res.dout_enable = 1'b1;
                    res.dout_drive  = setup_next[3'(Q_SETUP_LAST - qn)];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            pulse_reg  <= '0;
            half_reg   <= '0;
            wait_reg   <= '0;
            sample_reg <= '0;
            setup_reg  <= '0;
            devset_reg <= CHAN0_SETUP_RST;
            pend_reg   <= 1'b0;
            tgt_reg    <= 1'b0;
            iswr_reg   <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            pulse_reg  <= pulse_next;
            half_reg   <= half_next;
            wait_reg   <= wait_next;
            sample_reg <= sample_next;
            setup_reg  <= setup_next;
            devset_reg <= devset_next;
            pend_reg   <= pend_next;
            tgt_reg    <= tgt_next;
            iswr_reg   <= iswr_next;
        end
    end

endmodule

/* rtl/twadc_out.sv */
// Result register with valid/ready toward the receiver.
// Depends on twadc_pkg.
module twadc_out (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  twadc_pkg::res_t    res_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               room,
    output twadc_pkg::res_t    res_out
);
    import twadc_pkg::*;

    logic valid_reg;
    res_t data_reg;

    // a full register frees up on the same edge its transfer completes
    assign room      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign res_out   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= res_in;
        end
    end

endmodule

/* rtl/two_wire_adc_serial_master.sv */
// Top level of the two-wire serial master for a two-channel bridge converter.
// Instantiates twadc_cfg, twadc_seq and twadc_out; depends on twadc_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready, opcode/channel/dout_in): one transfer
//   is one tick of the pin sequencer. opcode requests a conversion read or a
//   setup write; requests while busy are dropped.
//   Output channel (out_valid/out_ready): every input transfer yields one
//   result carrying the pin levels after that tick and, on the finishing
//   tick, done/status/sample/setup_readback.
//   Config channel (cfg_valid/cfg_ready, cfg_index/cfg_data): always ready;
//   write only while idle.
// Timing: each result is registered and appears in the cycle after its input transfer.
// Throughput: one tick per cycle unless stalled; the whole tick update sits
//   between the sequencer state registers and the result register.
// Stall: while the result register holds an untaken result, in_ready drops;
//   it stays high if out_ready is high, so a full-rate stream never stops.
// Reset: sequencer idle, stored device setup = channel A reset value,
//   config registers at their reset values, no result pending.
module two_wire_adc_serial_master #(
    parameter int SAMPLE_BITS = twadc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             opcode,
    input  logic                   channel,
    input  logic                   dout_in,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   sck_level,
    output logic                   dout_drive,
    output logic                   dout_enable,
    output logic                   busy_res,
    output logic                   done_res,
    output logic                   status,
    output logic [SAMPLE_BITS-1:0] sample,
    output logic [7:0]             setup_readback,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [31:0]            cfg_data
);
    import twadc_pkg::*;

    cfg_t cfg;
    res_t res_tick;
    res_t res_q;
    logic room;
    logic advance;

    assign in_ready = room;
    assign advance  = in_valid && room;

    twadc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    twadc_seq #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .opcode  (opcode),
        .channel (channel),
        .dout_in (dout_in),
        .cfg     (cfg),
        .res     (res_tick)
    );

    twadc_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .res_in    (res_tick),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .room      (room),
        .res_out   (res_q)
    );

    assign sck_level      = res_q.sck_level;
    assign dout_drive     = res_q.dout_drive;
    assign dout_enable    = res_q.dout_enable;
    assign busy_res       = res_q.busy_res;
    assign done_res       = res_q.done_res;
    assign status         = res_q.status;
    assign sample         = res_q.sample[SAMPLE_BITS-1:0];
    assign setup_readback = res_q.setup_readback;

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input taken while result register is stalled");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("input transfer produced no result");

    a_done_releases_pins: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> (!sck_level && !dout_enable && !busy_res))
        else $error("pins still driven on a finishing tick");

endmodule
